>>> rtl/core/jps_pkg.sv
`timescale 1ns / 1ps
package jps_pkg;

   // serial multiplier: A operand, B operand walked one bit a cycle
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // serial restoring divider: one quotient bit a cycle
   localparam int DIV_N_W = 68;
   localparam int DIV_D_W = 34;

   localparam int JOINT_ID_DEF       = 0;
   localparam int ENCODER_COUNTS_DEF = 4096;
   localparam int MOTOR_STEPS_DEF    = 200;
   localparam int TICK_MS_DEF        = 2;

   // Q16.16 turn constants
   localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
   localparam logic [17:0] PI_Q16     = 18'd205887;
   // 256 * 2pi, divisor of the step rate
   localparam logic [26:0] RATE_DEN   = 27'd105414400;
   localparam logic [23:0] RATE_MAX   = 24'hFFFFFF;

   // register indexes
   localparam logic [2:0] CSR_ENCODER_PRESENT = 3'd0;
   localparam logic [2:0] CSR_POSITION_GAIN   = 3'd1;
   localparam logic [2:0] CSR_VELOCITY_LIMIT  = 3'd2;
   localparam logic [2:0] CSR_GEAR_RATIO      = 3'd3;
   localparam logic [2:0] CSR_ANGLE_OFFSET    = 3'd4;
   localparam logic [2:0] CSR_MICROSTEP       = 3'd5;
   localparam logic [2:0] CSR_START_CLOCKS    = 3'd6;
   localparam logic [2:0] CSR_CLOCK_PERIOD    = 3'd7;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -48'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/joint_position_servo_unit.sv
`timescale 1ns / 1ps
// Joint position servo: P controller with velocity feedforward, one instance per joint.
// req_ channel: one word per command. tuser = action (0 set goal, 1 control tick).
//   A set word stores goal position/velocity; a tick updates the position estimate
//   (integrated velocity, or decoded encoder pulse width) and runs the control law.
//   Words for another joint are answered with accepted = 0 and zero fields.
// rsp_ channel: exactly one word back per request word, in order.
// csr_ port: single-cycle register writes, made by the user only while the block is idle (not enforced).
// Work per word: a set or other-joint word is answered without the arithmetic units. A tick
//   with the encoder and no pulse data keeps the position estimate and goes straight to
//   the control law. A divider pass yields 68 quotient bits; an integrating tick makes
//   two divider and three multiplier passes, a decoding tick four and five. One word is
//   worked on at a time; the next is taken in the cycle its predecessor's result is offered.
// Reset (synchronous): registers go to their defaults, servo state clears.
// A stalled rsp_ side does not block the next request: the finished word sits in the
//   output register and the next one is worked on, waiting only to hand over its result.
module joint_position_servo_unit import jps_pkg::*; #(
   parameter int JOINT_ID       = JOINT_ID_DEF,
   parameter int ENCODER_COUNTS = ENCODER_COUNTS_DEF,
   parameter int MOTOR_STEPS    = MOTOR_STEPS_DEF,
   parameter int TICK_MS        = TICK_MS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // joint[2:0], target_position[34:3], target_velocity[66:35], pulse_width_us[82:67]
   input  logic [87:0]  req_tdata,
   // action
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // joint_angle[31:0], tracking_error[63:32], speed_demand[95:64],
   // direction[96], step_rate[120:97]
   output logic [127:0] rsp_tdata,
   // accepted
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [30:0]  csr_wdata
);
   localparam logic [2:0]  JOINT_V    = 3'(JOINT_ID);
   localparam logic [6:0]  TICK_V     = 7'(TICK_MS);
   localparam logic [9:0]  STEPS_V    = 10'(MOTOR_STEPS);
   localparam logic [32:0] FULL_Q16   = 33'(ENCODER_COUNTS) << 16;
   localparam logic [32:0] LAST_Q16   = FULL_Q16 - 33'd65536;
   localparam logic [33:0] MS_PER_S   = 34'd1000;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_DISPATCH   = 4'd1;
   localparam logic [3:0] S_INT_WAIT   = 4'd2;
   localparam logic [3:0] S_DEC1_WAIT  = 4'd3;
   localparam logic [3:0] S_DEC2_WAIT  = 4'd4;
   localparam logic [3:0] S_DEC3_WAIT  = 4'd5;
   localparam logic [3:0] S_WRAP       = 4'd6;
   localparam logic [3:0] S_DEC4_WAIT  = 4'd7;
   localparam logic [3:0] S_DEC5_WAIT  = 4'd8;
   localparam logic [3:0] S_CTL        = 4'd9;
   localparam logic [3:0] S_CTL_WAIT   = 4'd10;
   localparam logic [3:0] S_RATE1_WAIT = 4'd11;
   localparam logic [3:0] S_RATE2_WAIT = 4'd12;
   localparam logic [3:0] S_RATE3_WAIT = 4'd13;
   localparam logic [3:0] S_DONE       = 4'd14;

   // configuration
   logic               enc_ff;
   logic [15:0]        gain_ff;
   logic [30:0]        vlim_ff;
   logic [15:0]        gear_ff;
   logic signed [19:0] offs_ff;
   logic [8:0]         micro_ff;
   logic [7:0]         sclk_ff;
   logic [15:0]        period_ff;

   // servo state
   logic [3:0]         state_ff, state_in;
   logic signed [31:0] goal_pos_ff, goal_pos_in;
   logic signed [31:0] goal_vel_ff, goal_vel_in;
   logic signed [31:0] pos_ff, pos_in;
   logic signed [31:0] lvc_ff, lvc_in;
   logic signed [15:0] tc_ff, tc_in;
   logic [18:0]        prev_ff, prev_in;

   // captured word and work registers
   logic               act_ff, act_in;
   logic [2:0]         joint_ff, joint_in;
   logic signed [31:0] tpos_ff, tpos_in;
   logic signed [31:0] tvel_ff, tvel_in;
   logic [15:0]        pw_ff, pw_in;
   logic [18:0]        ang_ff, ang_in;
   logic               neg_ff, neg_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] v_ff, v_in;
   logic [127:0]       res_data_ff, res_data_in;
   logic               res_user_ff, res_user_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [127:0]       rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   // arithmetic units
   logic               mul_start_ff, mul_start_in;
   logic [MUL_A_W-1:0] mul_a_ff, mul_a_in;
   logic [MUL_B_W-1:0] mul_b_ff, mul_b_in;
   logic               mul_done;
   logic [MUL_P_W-1:0] mul_p;
   logic               div_start_ff, div_start_in;
   logic [DIV_N_W-1:0] div_n_ff, div_n_in;
   logic [DIV_D_W-1:0] div_d_ff, div_d_in;
   logic               div_done;
   logic [DIV_N_W-1:0] div_q;

   // datapath terms
   logic [31:0]        lvc_abs;
   logic [38:0]        int_prod;
   logic signed [47:0] int_step;
   logic [25:0]        pw_ns;
   logic signed [43:0] cq;
   logic [32:0]        cq_cl;
   logic signed [21:0] tp22;
   logic signed [21:0] w0, w1, w2, w3, w4;
   logic [18:0]        ang_wrap;
   logic signed [20:0] delta;
   logic signed [15:0] tc_new;
   logic [15:0]        tc_abs;
   logic signed [36:0] tc_term;
   logic signed [36:0] total;
   logic [35:0]        tot_abs;
   logic signed [47:0] gdiv;
   logic signed [31:0] err_c;
   logic [31:0]        err_abs;
   logic signed [47:0] gterm;
   logic signed [47:0] vsum;
   logic signed [47:0] vlim48;
   logic signed [47:0] vcl;
   logic [18:0]        steps_b;
   logic [23:0]        rate;
   logic               in_accept;
   logic               out_free;

   jps_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start_ff),
      .a     (mul_a_ff),
      .b     (mul_b_ff),
      .done  (mul_done),
      .p     (mul_p)
   );

   jps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .n     (div_n_ff),
      .d     (div_d_ff),
      .done  (div_done),
      .q     (div_q)
   );

   assign in_accept = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   // integration: |lvc| * tick, divided by 1000 below
   assign lvc_abs  = lvc_ff[31] ? 32'(-lvc_ff) : 32'(lvc_ff);
   assign int_prod = 39'(lvc_abs) * 39'(TICK_V);
   assign int_step = neg_ff ? -$signed({9'b0, div_q[38:0]}) : $signed({9'b0, div_q[38:0]});

   // encoder counts in Q16, less the start clocks, clamped to the encoder range
   assign pw_ns = 26'(pw_ff) * 26'd1000;
   assign cq    = $signed({2'b00, div_q[41:0]}) - $signed({20'b0, sclk_ff, 16'h0000});
   always_comb begin
      if (cq < 44'sd0) begin
         cq_cl = '0;
      end else if (cq >= $signed({11'b0, FULL_Q16})) begin
         cq_cl = LAST_Q16;
      end else begin
         cq_cl = cq[32:0];
      end
   end

   // offset and wrap into one turn; the offset may reach past a full turn either way
   assign tp22 = $signed({3'b000, TWO_PI_Q16});
   assign w0   = $signed({3'b000, ang_ff}) + 22'(offs_ff);
   assign w1   = (w0 < 22'sd0) ? w0 + tp22 : w0;
   assign w2   = (w1 < 22'sd0) ? w1 + tp22 : w1;
   assign w3   = (w2 >= tp22) ? w2 - tp22 : w2;
   assign w4   = (w3 >= tp22) ? w3 - tp22 : w3;
   assign ang_wrap = w4[18:0];

   // turn tracking: a jump of more than half a turn is a wrap
   assign delta = $signed({2'b00, ang_wrap}) - $signed({2'b00, prev_ff});
   always_comb begin
      tc_new = tc_ff;
      if (delta > $signed({3'b000, PI_Q16}) && tc_ff != 16'sh8000) begin
         tc_new = tc_ff - 16'sd1;
      end
      if (delta < -$signed({3'b000, PI_Q16}) && tc_ff != 16'sh7FFF) begin
         tc_new = tc_ff + 16'sd1;
      end
   end
   assign tc_abs = tc_new[15] ? 16'(-tc_new) : 16'(tc_new);

   // multi-turn angle, then division by the gear ratio on the magnitude
   assign tc_term = neg_ff ? -$signed({3'b000, mul_p[33:0]}) : $signed({3'b000, mul_p[33:0]});
   assign total   = $signed({18'b0, ang_ff}) + tc_term;
   assign tot_abs = total[36] ? 36'(-total) : 36'(total);
   assign gdiv    = neg_ff ? -$signed({4'b0, div_q[43:0]}) : $signed({4'b0, div_q[43:0]});

   // control law
   assign err_c   = sat32(48'(goal_pos_ff) - 48'(pos_ff));
   assign err_abs = err_c[31] ? 32'(-err_c) : 32'(err_c);
   assign gterm   = neg_ff ? -$signed({8'b0, mul_p[47:8]}) : $signed({8'b0, mul_p[47:8]});
   assign vsum    = 48'(goal_vel_ff) + gterm;
   assign vlim48  = $signed({17'b0, vlim_ff});
   always_comb begin
      if (vsum > vlim48) begin
         vcl = vlim48;
      end else if (vsum < -vlim48) begin
         vcl = -vlim48;
      end else begin
         vcl = vsum;
      end
   end
   assign steps_b = 19'(STEPS_V) * 19'(micro_ff);
   assign rate    = (|div_q[DIV_N_W-1:24]) ? RATE_MAX : div_q[23:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      goal_pos_in  = goal_pos_ff;
      goal_vel_in  = goal_vel_ff;
      pos_in       = pos_ff;
      lvc_in       = lvc_ff;
      tc_in        = tc_ff;
      prev_in      = prev_ff;
      act_in       = act_ff;
      joint_in     = joint_ff;
      tpos_in      = tpos_ff;
      tvel_in      = tvel_ff;
      pw_in        = pw_ff;
      ang_in       = ang_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      v_in         = v_ff;
      res_data_in  = res_data_ff;
      res_user_in  = res_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mul_start_in = 1'b0;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      div_start_in = 1'b0;
      div_n_in     = div_n_ff;
      div_d_in     = div_d_ff;

      case (state_ff)
         S_IDLE: begin
            if (in_accept) begin
               act_in   = req_tuser;
               joint_in = req_tdata[2:0];
               tpos_in  = req_tdata[34:3];
               tvel_in  = req_tdata[66:35];
               pw_in    = req_tdata[82:67];
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (joint_ff != JOINT_V) begin
               res_data_in = '0;
               res_user_in = 1'b0;
               state_in    = S_DONE;
            end else if (!act_ff) begin
               goal_pos_in = tpos_ff;
               goal_vel_in = tvel_ff;
               res_data_in = {96'b0, pos_ff};
               res_user_in = 1'b1;
               state_in    = S_DONE;
            end else if (!enc_ff) begin
               neg_in       = lvc_ff[31];
               div_n_in     = DIV_N_W'(int_prod);
               div_d_in     = MS_PER_S;
               div_start_in = 1'b1;
               state_in     = S_INT_WAIT;
            end else if (pw_ff == 16'h0000) begin
               state_in = S_CTL;
            end else begin
               div_n_in     = DIV_N_W'({pw_ns, 16'h0000});
               div_d_in     = (period_ff == 16'h0000) ? DIV_D_W'(1) : DIV_D_W'(period_ff);
               div_start_in = 1'b1;
               state_in     = S_DEC1_WAIT;
            end
         end
         S_INT_WAIT: begin
            if (div_done) begin
               pos_in   = sat32(48'(pos_ff) + int_step);
               state_in = S_CTL;
            end
         end
         S_DEC1_WAIT: begin
            if (div_done) begin
               mul_a_in     = MUL_A_W'(cq_cl);
               mul_b_in     = MUL_B_W'(TWO_PI_Q16);
               mul_start_in = 1'b1;
               state_in     = S_DEC2_WAIT;
            end
         end
         S_DEC2_WAIT: begin
            if (mul_done) begin
               div_n_in     = mul_p[DIV_N_W-1:0];
               div_d_in     = DIV_D_W'(FULL_Q16);
               div_start_in = 1'b1;
               state_in     = S_DEC3_WAIT;
            end
         end
         S_DEC3_WAIT: begin
            if (div_done) begin
               ang_in   = div_q[18:0];
               state_in = S_WRAP;
            end
         end
         S_WRAP: begin
            ang_in       = ang_wrap;
            prev_in      = ang_wrap;
            tc_in        = tc_new;
            neg_in       = tc_new[15];
            mul_a_in     = MUL_A_W'(tc_abs);
            mul_b_in     = MUL_B_W'(TWO_PI_Q16);
            mul_start_in = 1'b1;
            state_in     = S_DEC4_WAIT;
         end
         S_DEC4_WAIT: begin
            if (mul_done) begin
               neg_in       = total[36];
               div_n_in     = DIV_N_W'({tot_abs, 8'h00});
               div_d_in     = (gear_ff == 16'h0000) ? DIV_D_W'(1) : DIV_D_W'(gear_ff);
               div_start_in = 1'b1;
               state_in     = S_DEC5_WAIT;
            end
         end
         S_DEC5_WAIT: begin
            if (div_done) begin
               pos_in   = sat32(gdiv);
               state_in = S_CTL;
            end
         end
         S_CTL: begin
            err_in       = err_c;
            neg_in       = err_c[31];
            mul_a_in     = MUL_A_W'(gain_ff);
            mul_b_in     = err_abs;
            mul_start_in = 1'b1;
            state_in     = S_CTL_WAIT;
         end
         S_CTL_WAIT: begin
            if (mul_done) begin
               v_in     = vcl[31:0];
               lvc_in   = vcl[31:0];
               state_in = S_RATE1_WAIT;
               mul_a_in = MUL_A_W'(vcl[31] ? 32'(-vcl[31:0]) : 32'(vcl[31:0]));
               mul_b_in = MUL_B_W'(gear_ff);
               mul_start_in = 1'b1;
            end
         end
         S_RATE1_WAIT: begin
            if (mul_done) begin
               mul_a_in     = mul_p[MUL_A_W-1:0];
               mul_b_in     = MUL_B_W'(steps_b);
               mul_start_in = 1'b1;
               state_in     = S_RATE2_WAIT;
            end
         end
         S_RATE2_WAIT: begin
            if (mul_done) begin
               div_n_in     = mul_p[DIV_N_W-1:0];
               div_d_in     = DIV_D_W'(RATE_DEN);
               div_start_in = 1'b1;
               state_in     = S_RATE3_WAIT;
            end
         end
         S_RATE3_WAIT: begin
            if (div_done) begin
               res_data_in = {7'b0, rate, !v_ff[31], v_ff, err_ff, pos_ff};
               res_user_in = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_user_in  = res_user_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         goal_pos_ff  <= '0;
         goal_vel_ff  <= '0;
         pos_ff       <= '0;
         lvc_ff       <= '0;
         tc_ff        <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         goal_pos_ff  <= goal_pos_in;
         goal_vel_ff  <= goal_vel_in;
         pos_ff       <= pos_in;
         lvc_ff       <= lvc_in;
         tc_ff        <= tc_in;
         prev_ff      <= prev_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      joint_ff    <= joint_in;
      tpos_ff     <= tpos_in;
      tvel_ff     <= tvel_in;
      pw_ff       <= pw_in;
      ang_ff      <= ang_in;
      neg_ff      <= neg_in;
      err_ff      <= err_in;
      v_ff        <= v_in;
      res_data_ff <= res_data_in;
      res_user_ff <= res_user_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      div_n_ff    <= div_n_in;
      div_d_ff    <= div_d_in;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enc_ff    <= 1'b0;
         gain_ff   <= '0;
         vlim_ff   <= '0;
         gear_ff   <= 16'd256;
         offs_ff   <= '0;
         micro_ff  <= 9'd1;
         sclk_ff   <= '0;
         period_ff <= 16'd1000;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ENCODER_PRESENT: enc_ff    <= csr_wdata[0];
            CSR_POSITION_GAIN:   gain_ff   <= csr_wdata[15:0];
            CSR_VELOCITY_LIMIT:  vlim_ff   <= csr_wdata[30:0];
            CSR_GEAR_RATIO:      gear_ff   <= csr_wdata[15:0];
            CSR_ANGLE_OFFSET:    offs_ff   <= csr_wdata[19:0];
            CSR_MICROSTEP:       micro_ff  <= csr_wdata[8:0];
            CSR_START_CLOCKS:    sclk_ff   <= csr_wdata[7:0];
            CSR_CLOCK_PERIOD:    period_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // previous angle always lies within one turn
   a_prev_range: assert property (@(posedge clock) disable iff (reset)
      prev_ff < TWO_PI_Q16)
      else $error("previous angle out of range");

   // multiplier and divider are never launched together
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_start_ff && div_start_ff))
      else $error("both units started");

   // a word for another joint leaves goals and estimate untouched
   a_other_joint: assert property (@(posedge clock) disable iff (reset)
      (in_accept && req_tdata[2:0] != JOINT_V) |-> ##2
         ($stable(goal_pos_ff) && $stable(goal_vel_ff) && $stable(pos_ff)))
      else $error("state changed for another joint");

endmodule

>>> rtl/core/jps_mul.sv
`timescale 1ns / 1ps
// shift-add multiplier, one bit of b per cycle
module jps_mul import jps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic               done,
   output logic [MUL_P_W-1:0] p
);
   localparam int CW = $clog2(MUL_B_W + 1);

   logic [MUL_A_W-1:0] a_ff;
   logic [MUL_A_W-1:0] hi_ff;
   logic [MUL_B_W-1:0] lo_ff;
   logic [CW-1:0]      cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [MUL_A_W:0]   sum;

   assign sum = {1'b0, hi_ff} + {1'b0, (lo_ff[0] ? a_ff : {MUL_A_W{1'b0}})};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(MUL_B_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         hi_ff <= '0;
         lo_ff <= b;
      end else if (busy_ff) begin
         hi_ff <= sum[MUL_A_W:1];
         lo_ff <= {sum[0], lo_ff[MUL_B_W-1:1]};
      end
   end

   assign done = done_ff;
   assign p    = {hi_ff, lo_ff};

endmodule

>>> rtl/core/jps_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module jps_div import jps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] n,
   input  logic [DIV_D_W-1:0] d,
   output logic               done,
   output logic [DIV_N_W-1:0] q
);
   localparam int CW = $clog2(DIV_N_W + 1);

   logic [DIV_N_W-1:0] num_ff;
   logic [DIV_D_W-1:0] den_ff;
   logic [DIV_D_W-1:0] rem_ff;
   logic [CW-1:0]      cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DIV_D_W:0]   trial;
   logic [DIV_D_W:0]   diff;
   logic               ge;

   assign trial = {rem_ff, num_ff[DIV_N_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DIV_N_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= n;
         den_ff <= d;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         num_ff <= {num_ff[DIV_N_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign q    = num_ff;

endmodule
